// ===== hdl/dense_rank_layout_engine_assert.svh =====
// Assertion macros for the port-level checker of the dense rank layout engine.
`ifndef DENSE_RANK_LAYOUT_ENGINE_ASSERT_SVH
`define DENSE_RANK_LAYOUT_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DRLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DRLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/drle_pkg.sv =====
// Types and constants of the dense rank layout engine.
`default_nettype none

package drle_pkg;

	localparam int ROW_W    = 24;
	localparam int PRED_W   = 10;
	localparam int CNT_W    = 11;
	localparam int OFFS_W   = 34;
	localparam int START_W  = 35;
	localparam int REGIDX_W = 2;

	// Input function codes.
	localparam logic FUNC_RUN   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Result kinds.
	localparam logic KIND_LAYOUT = 1'b0;
	localparam logic KIND_RANGE  = 1'b1;

	// Configuration register indexes.
	localparam logic [REGIDX_W-1:0] REG_N_ROW     = 2'd0;
	localparam logic [REGIDX_W-1:0] REG_N_PRED    = 2'd1;
	localparam logic [REGIDX_W-1:0] REG_DENSE_THR = 2'd2;

	typedef struct packed {
		logic              func;
		logic [ROW_W-1:0]  run_rank;
		logic [ROW_W-1:0]  run_extent;
		logic              last_run;
		logic [PRED_W-1:0] query_pred;
		logic [ROW_W-1:0]  bag_count;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [PRED_W-1:0]  pred_index;
		logic               is_dense;
		logic [ROW_W-1:0]   dense_rank;
		logic [ROW_W-1:0]   explicit_count;
		logic [OFFS_W-1:0]  slot_offset;
		logic [CNT_W-1:0]   dense_index;
		logic [START_W-1:0] range_start;
		logic [ROW_W-1:0]   range_length;
	} result_t;

	typedef struct packed {
		logic [REGIDX_W-1:0] reg_index;
		logic [ROW_W-1:0]    wr_data;
	} cfg_t;

	// One layout table entry.
	typedef struct packed {
		logic              dense;
		logic [ROW_W-1:0]  rank;
		logic [ROW_W-1:0]  expl;
		logic [OFFS_W-1:0] offset;
		logic [CNT_W-1:0]  didx;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hdl/drle_stream_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`default_nettype none

interface drle_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/drle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module drle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/dense_rank_layout_engine.sv =====
// Top level of the dense rank layout engine: run merging, layout table and range queries.
// Run beats that are not last are taken one per cycle unless stalled, and give no result.
// A last run gives its layout summary through stage one and the output register; the input
// holds off while it sits in stage one so that the table write lands before any later read.
// Range queries go one per cycle unless stalled; answers pass the table read and output register.
// Reset clears control state and counters, presets configuration; the layout table is not cleared.
`default_nettype none

module dense_rank_layout_engine #(
	parameter int MAX_PRED = 1024,
	parameter int ROW_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	drle_stream_if.sink   item,
	drle_stream_if.source result,
	drle_stream_if.sink   cfg
);

	import drle_pkg::*;

	// Rank and extent keep at most ROW_BITS bits, and never more than the field width.
	localparam int RANK_W    = (ROW_BITS < ROW_W) ? ROW_BITS : ROW_W;
	localparam int WIDE_W    = (ROW_BITS > ROW_W) ? ROW_BITS : ROW_W;
	// Predictor numbers are 10 bits, so the table never needs more than 2**PRED_W rows.
	localparam int TBL_DEPTH = (MAX_PRED < (1 << PRED_W)) ? MAX_PRED : (1 << PRED_W);
	localparam int AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls; writes to an index
	// beyond the register list are taken and dropped.
	// ------------------------------------------------------------------
	logic [ROW_W-1:0] n_row_q;
	logic [CNT_W-1:0] n_pred_q;
	logic [ROW_W-1:0] thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_row_q  <= ROW_W'(1);
			n_pred_q <= CNT_W'(1);
			thr_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				REG_N_ROW:     n_row_q  <= cfg.data.wr_data;
				REG_N_PRED:    n_pred_q <= cfg.data.wr_data[CNT_W-1:0];
				REG_DENSE_THR: thr_q    <= cfg.data.wr_data;
				default:       ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake. A result waits in the output register, and stage one holds
	// its own while the output stalls; it moves on whenever the output is free
	// or being drained. While a last run sits in stage one the input holds off
	// so the table write and the counter update finish before the next beat.
	// ------------------------------------------------------------------
	logic out_valid_q;
	result_t out_data_q;
	logic out_stall;
	logic valid_s1;
	logic kind_s1;
	logic item_acc;
	logic is_query;
	logic load_s1;

	assign out_stall  = out_valid_q && !result.ready;
	assign item.ready = !out_stall && !(valid_s1 && kind_s1 == KIND_LAYOUT);
	assign item_acc   = item.valid && item.ready;
	assign is_query   = item.data.func == FUNC_QUERY;
	assign load_s1    = item_acc && (is_query || item.data.last_run);

	// ------------------------------------------------------------------
	// Stage zero: merge equal adjacent ranks and track the longest run.
	// The merged total saturates at the all-ones row value, and a run
	// replaces the best only when strictly longer.
	// ------------------------------------------------------------------
	logic [PRED_W-1:0]   cur_pred_q;
	logic [RANK_W-1:0]   prev_rank_q;
	logic                prev_valid_q;
	logic [ROW_BITS-1:0] run_total_q;
	logic [ROW_BITS-1:0] best_total_q;
	logic [RANK_W-1:0]   best_rank_q;

	logic [RANK_W-1:0]   rank_in;
	logic [ROW_BITS-1:0] ext_in;
	logic                same_run;
	logic [ROW_BITS:0]   run_sum;
	logic [ROW_BITS-1:0] run_total_new;
	logic                better;
	logic [ROW_BITS-1:0] best_total_new;
	logic [RANK_W-1:0]   best_rank_new;

	always_comb begin
		rank_in        = item.data.run_rank[RANK_W-1:0];
		ext_in         = ROW_BITS'(item.data.run_extent[RANK_W-1:0]);
		same_run       = prev_valid_q && (rank_in == prev_rank_q);
		run_sum        = {1'b0, run_total_q} + {1'b0, ext_in};
		if (!same_run) begin
			run_total_new = ext_in;
		end else if (run_sum[ROW_BITS]) begin
			run_total_new = '1;
		end else begin
			run_total_new = run_sum[ROW_BITS-1:0];
		end
		better         = run_total_new > best_total_q;
		best_total_new = better ? run_total_new : best_total_q;
		best_rank_new  = better ? rank_in : best_rank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pred_q   <= '0;
			prev_rank_q  <= '0;
			prev_valid_q <= 1'b0;
			run_total_q  <= '0;
			best_total_q <= '0;
			best_rank_q  <= '0;
		end else if (item_acc && !is_query) begin
			if (item.data.last_run) begin
				// Predictor done: start the next one from a clean slate.
				cur_pred_q   <= cur_pred_q + PRED_W'(1);
				prev_rank_q  <= '0;
				prev_valid_q <= 1'b0;
				run_total_q  <= '0;
				best_total_q <= '0;
				best_rank_q  <= '0;
			end else begin
				prev_rank_q  <= rank_in;
				prev_valid_q <= 1'b1;
				run_total_q  <= run_total_new;
				best_total_q <= best_total_new;
				best_rank_q  <= best_rank_new;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage one registers: either a finished predictor (best run) or a
	// query whose table row is being read. The non-compact count is
	// captured with the query beat, as it stood when the beat arrived.
	// ------------------------------------------------------------------
	logic [PRED_W-1:0]   pred_s1;
	logic                hit_s1;
	logic [ROW_BITS-1:0] best_total_s1;
	logic [RANK_W-1:0]   best_rank_s1;
	logic [ROW_W-1:0]    bag_s1;
	logic [CNT_W-1:0]    nc_s1;

	logic [CNT_W-1:0]  nc_count_q;
	logic [OFFS_W-1:0] compact_q;
	logic [CNT_W-1:0]  dense_count_q;

	logic [PRED_W-1:0] pred_in;

	assign pred_in = is_query ? item.data.query_pred : cur_pred_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!out_stall) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1       <= is_query ? KIND_RANGE : KIND_LAYOUT;
			pred_s1       <= pred_in;
			hit_s1        <= {1'b0, pred_in} < CNT_W'(TBL_DEPTH);
			best_total_s1 <= best_total_new;
			best_rank_s1  <= best_rank_new;
			bag_s1        <= item.data.bag_count;
			nc_s1         <= nc_count_q;
		end
	end

	// ------------------------------------------------------------------
	// Layout table. The read address follows the incoming beat, and is
	// held on the stage-one row while the output is stalled so the read
	// data stays valid. A row is written when its summary leaves stage one.
	// ------------------------------------------------------------------
	logic               tbl_we;
	logic [AW-1:0]      tbl_raddr;
	logic [ENTRY_W-1:0] tbl_rdata;
	entry_t             lay_entry;

	assign tbl_we    = valid_s1 && kind_s1 == KIND_LAYOUT && !out_stall && hit_s1;
	assign tbl_raddr = (valid_s1 && out_stall) ? pred_s1[AW-1:0]
		: item.data.query_pred[AW-1:0];

	drle_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TBL_DEPTH)
	) u_layout_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (pred_s1[AW-1:0]),
		.wdata (lay_entry),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// ------------------------------------------------------------------
	// Stage one logic. A predictor is dense when its longest run exceeds
	// the threshold; its explicit count is n_row less that run, floored at
	// zero. Dense predictors take the running compact length, the others
	// the next non-compact slot. A range answer for a dense predictor
	// starts past all non-compact slots; for the others at its slot.
	// ------------------------------------------------------------------
	logic              is_dense;
	logic [WIDE_W-1:0] best_wide;
	logic [WIDE_W-1:0] nrow_wide;
	logic [ROW_W-1:0]  expl;
	entry_t            qry_entry;
	logic [CNT_W-1:0]  mul_a;
	logic [START_W-1:0] prod;
	result_t           res_s1;

	always_comb begin
		best_wide = WIDE_W'(best_total_s1);
		nrow_wide = WIDE_W'(n_row_q);
		is_dense  = best_wide > WIDE_W'(thr_q);
		expl      = (nrow_wide >= best_wide) ? ROW_W'(nrow_wide - best_wide) : '0;

		if (is_dense) begin
			lay_entry.dense  = 1'b1;
			lay_entry.rank   = ROW_W'(best_rank_s1);
			lay_entry.expl   = expl;
			lay_entry.offset = compact_q;
			lay_entry.didx   = dense_count_q;
		end else begin
			lay_entry.dense  = 1'b0;
			lay_entry.rank   = '0;
			lay_entry.expl   = n_row_q;
			lay_entry.offset = OFFS_W'(nc_count_q);
			lay_entry.didx   = n_pred_q;
		end

		// Rows beyond the table answer as an all-zero entry.
		qry_entry = hit_s1 ? entry_t'(tbl_rdata) : '0;
		mul_a     = qry_entry.dense ? nc_s1 : qry_entry.offset[CNT_W-1:0];
		prod      = START_W'(mul_a) * START_W'(bag_s1);

		if (kind_s1 == KIND_RANGE) begin
			res_s1.kind           = KIND_RANGE;
			res_s1.is_dense       = qry_entry.dense;
			res_s1.dense_rank     = qry_entry.rank;
			res_s1.explicit_count = qry_entry.expl;
			res_s1.slot_offset    = qry_entry.offset;
			res_s1.dense_index    = qry_entry.didx;
			res_s1.range_start    = qry_entry.dense ? prod + START_W'(qry_entry.offset) : prod;
			res_s1.range_length   = qry_entry.dense ? qry_entry.expl : bag_s1;
		end else begin
			res_s1.kind           = KIND_LAYOUT;
			res_s1.is_dense       = lay_entry.dense;
			res_s1.dense_rank     = lay_entry.rank;
			res_s1.explicit_count = lay_entry.expl;
			res_s1.slot_offset    = lay_entry.offset;
			res_s1.dense_index    = lay_entry.didx;
			res_s1.range_start    = '0;
			res_s1.range_length   = '0;
		end
		res_s1.pred_index = pred_s1;
	end

	// Slot counters advance as a summary leaves stage one; they wrap at their widths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_count_q    <= '0;
			compact_q     <= '0;
			dense_count_q <= '0;
		end else if (valid_s1 && kind_s1 == KIND_LAYOUT && !out_stall) begin
			if (is_dense) begin
				dense_count_q <= dense_count_q + CNT_W'(1);
				compact_q     <= compact_q + OFFS_W'(expl);
			end else begin
				nc_count_q <= nc_count_q + CNT_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_stall && valid_s1) begin
			out_data_q <= res_s1;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/drle_checker.sv =====
// Port-level checker for the dense rank layout engine and its bind.
`default_nettype none

`include "dense_rank_layout_engine_assert.svh"

module drle_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input drle_pkg::result_t res_data
);

	import drle_pkg::*;

	`DRLE_ASSERT_NXT(a_res_valid_hold, res_valid && !res_ready, res_valid, "result beat dropped while stalled")
	`DRLE_ASSERT_NXT(a_res_data_hold, res_valid && !res_ready, $stable(res_data), "result beat changed while stalled")
	`DRLE_ASSERT_IMP(a_layout_no_range, res_valid && res_data.kind == KIND_LAYOUT, res_data.range_start == '0 && res_data.range_length == '0, "layout summary carries a range")
	`DRLE_ASSERT_IMP(a_sparse_no_rank, res_valid && res_data.kind == KIND_LAYOUT && !res_data.is_dense, res_data.dense_rank == '0, "non-dense summary carries a dense rank")

endmodule

bind dense_rank_layout_engine drle_checker u_drle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

`default_nettype wire

// ===== sim/drle_layout_checker.sv =====
// Checker for the dense rank layout engine: tracks layout state, predicts results, compares.
module drle_layout_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  drle_pkg::item_t   item_beat,
	input  logic              result_valid,
	input  logic              result_ready,
	input  drle_pkg::result_t result_beat,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  drle_pkg::cfg_t    cfg_beat,
	output int                mismatches,
	output int                pending,
	output int                layouts_seen,
	output int                ranges_seen,
	output int                dense_seen
);
	import drle_pkg::*;

	// Register copies.
	logic [ROW_W-1:0]  n_row_q;
	logic [CNT_W-1:0]  n_pred_q;
	logic [ROW_W-1:0]  thr_q;

	// Run merging and layout bookkeeping.
	logic [PRED_W-1:0] cur_pred;
	logic [ROW_W-1:0]  last_rank;
	logic              have_rank;
	logic [ROW_W-1:0]  merged_len;
	logic [ROW_W-1:0]  longest_len;
	logic [ROW_W-1:0]  longest_rank;
	logic [CNT_W-1:0]  loose_slots;
	logic [OFFS_W-1:0] packed_len;
	logic [CNT_W-1:0]  dense_ord;
	entry_t            layout_mem [0:1023];

	result_t           expected_q [$];
	result_t           want;
	bit                made;

	function automatic string show(input result_t r);
		return $sformatf("kind=%0d pred=%0d dense=%0d rank=%h expl=%h slot=%h didx=%0d start=%h len=%h",
			r.kind, r.pred_index, r.is_dense, r.dense_rank, r.explicit_count,
			r.slot_offset, r.dense_index, r.range_start, r.range_length);
	endfunction

	task automatic absorb_beat(input item_t it, output bit got_one, output result_t res);
		entry_t           ent;
		logic [ROW_W:0]   sum;
		res     = '0;
		ent     = '0;
		got_one = 1'b0;
		if (it.func == FUNC_QUERY) begin
			ent = layout_mem[it.query_pred];
			if (!ent.dense) begin
				res.range_start  = START_W'(ent.offset[CNT_W-1:0]) * START_W'(it.bag_count);
				res.range_length = it.bag_count;
			end else begin
				res.range_start  = START_W'(loose_slots) * START_W'(it.bag_count)
					+ START_W'(ent.offset);
				res.range_length = ent.expl;
			end
			res.kind       = KIND_RANGE;
			res.pred_index = it.query_pred;
			got_one        = 1'b1;
			ranges_seen++;
		end else begin
			if (have_rank && it.run_rank == last_rank) begin
				sum        = {1'b0, merged_len} + {1'b0, it.run_extent};
				merged_len = sum[ROW_W] ? '1 : sum[ROW_W-1:0];
			end else begin
				merged_len = it.run_extent;
				last_rank  = it.run_rank;
				have_rank  = 1'b1;
			end
			// Only a strictly longer run takes over, so the first to reach the maximum stays.
			if (merged_len > longest_len) begin
				longest_len  = merged_len;
				longest_rank = it.run_rank;
			end
			if (it.last_run) begin
				ent.dense = longest_len > thr_q;
				if (ent.dense) begin
					ent.rank   = longest_rank;
					ent.expl   = (n_row_q >= longest_len) ? n_row_q - longest_len : '0;
					ent.offset = packed_len;
					ent.didx   = dense_ord;
					dense_ord  = dense_ord + CNT_W'(1);
					packed_len = packed_len + OFFS_W'(ent.expl);
					dense_seen++;
				end else begin
					ent.rank    = '0;
					ent.expl    = n_row_q;
					ent.offset  = OFFS_W'(loose_slots);
					ent.didx    = n_pred_q;
					loose_slots = loose_slots + CNT_W'(1);
				end
				layout_mem[cur_pred] = ent;
				res.kind       = KIND_LAYOUT;
				res.pred_index = cur_pred;
				got_one        = 1'b1;
				cur_pred       = cur_pred + PRED_W'(1);
				have_rank      = 1'b0;
				last_rank      = '0;
				merged_len     = '0;
				longest_len    = '0;
				longest_rank   = '0;
				layouts_seen++;
			end
		end
		if (got_one) begin
			res.is_dense       = ent.dense;
			res.dense_rank     = ent.rank;
			res.explicit_count = ent.expl;
			res.slot_offset    = ent.offset;
			res.dense_index    = ent.didx;
		end
	endtask

	task automatic compare_result(input result_t got);
		result_t exp_r;
		string   diffs;
		diffs = "";
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] unexpected result beat: %s", $realtime, show(got));
		end else begin
			exp_r = expected_q.pop_front();
			if (got.kind !== exp_r.kind) diffs = {diffs, " kind"};
			if (got.pred_index !== exp_r.pred_index) diffs = {diffs, " pred_index"};
			if (got.is_dense !== exp_r.is_dense) diffs = {diffs, " is_dense"};
			if (got.dense_rank !== exp_r.dense_rank) diffs = {diffs, " dense_rank"};
			if (got.explicit_count !== exp_r.explicit_count) diffs = {diffs, " explicit_count"};
			if (got.slot_offset !== exp_r.slot_offset) diffs = {diffs, " slot_offset"};
			if (got.dense_index !== exp_r.dense_index) diffs = {diffs, " dense_index"};
			if (got.range_start !== exp_r.range_start) diffs = {diffs, " range_start"};
			if (got.range_length !== exp_r.range_length) diffs = {diffs, " range_length"};
			if (diffs != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] result mismatch in%s", $realtime, diffs);
					$display("    expected %s", show(exp_r));
					$display("    actual   %s", show(got));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_row_q      = 24'd1;
			n_pred_q     = 11'd1;
			thr_q        = '0;
			cur_pred     = '0;
			last_rank    = '0;
			have_rank    = 1'b0;
			merged_len   = '0;
			longest_len  = '0;
			longest_rank = '0;
			loose_slots  = '0;
			packed_len   = '0;
			dense_ord    = '0;
			expected_q.delete();
			pending      = 0;
			mismatches   = 0;
			layouts_seen = 0;
			ranges_seen  = 0;
			dense_seen   = 0;
		end else begin
			if (result_valid && result_ready)
				compare_result(result_beat);
			if (cfg_valid && cfg_ready) begin
				case (cfg_beat.reg_index)
					REG_N_ROW:     n_row_q  = cfg_beat.wr_data;
					REG_N_PRED:    n_pred_q = cfg_beat.wr_data[CNT_W-1:0];
					REG_DENSE_THR: thr_q    = cfg_beat.wr_data;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				absorb_beat(item_beat, made, want);
				if (made)
					expected_q.push_back(want);
			end
			pending = expected_q.size();
		end
	end

endmodule

// ===== sim/tb_dense_rank_layout_engine.sv =====
// Testbench top for the dense rank layout engine: stimulus, flow control and verdict.
module tb_dense_rank_layout_engine;
	import drle_pkg::*;

	// Cycles without any accepted beat before the run is declared hung. The longest
	// legitimate quiet stretch is a receiver stall plus a sender gap, well under this.
	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;

	drle_stream_if #(.T(item_t))   item_ch ();
	drle_stream_if #(.T(result_t)) result_ch ();
	drle_stream_if #(.T(cfg_t))    cfg_ch ();

	int mismatches;
	int pending;
	int layouts_seen;
	int ranges_seen;
	int dense_seen;

	// Stimulus bookkeeping. preds_done counts last-run beats accepted; predictor
	// indexes below it (or all of them once the index has wrapped) hold a table entry.
	int items_sent;
	int queries_sent;
	int preds_done;
	int settings_used;
	int burst_left;
	int idle_cycles;
	int sink_mode;
	int sink_left;
	int phase;
	int phase_end;

	dense_rank_layout_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	drle_layout_checker layout_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_beat    (item_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_beat  (result_ch.data),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_beat     (cfg_ch.data),
		.mismatches   (mismatches),
		.pending      (pending),
		.layouts_seen (layouts_seen),
		.ranges_seen  (ranges_seen),
		.dense_seen   (dense_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result receiver. It switches between modes at random: always ready, mostly
	// ready, mostly stalled, and long stalls broken by short openings. Changes
	// land on the falling edge, like every other input.
	initial begin
		result_ch.ready = 1'b0;
		sink_mode       = 0;
		sink_left       = 0;
		forever begin
			@(negedge clk);
			if (sink_left == 0) begin
				sink_mode = $urandom_range(0, 3);
				sink_left = $urandom_range(20, 200);
			end
			sink_left--;
			case (sink_mode)
				0:       result_ch.ready <= 1'b1;
				1:       result_ch.ready <= ($urandom_range(0, 9) < 7);
				2:       result_ch.ready <= ($urandom_range(0, 9) < 3);
				default: result_ch.ready <= ((sink_left % 32) < 4);
			endcase
		end
	end

	// Watchdog: any accepted beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("FAIL dense_rank_layout_engine");
			$finish;
		end
	end

	// A run beat. The query fields are ignored by the block, so they carry noise.
	function automatic item_t run_beat(input logic [ROW_W-1:0] rank,
			input logic [ROW_W-1:0] ext, input logic is_last);
		item_t it;
		it.func       = FUNC_RUN;
		it.run_rank   = rank;
		it.run_extent = ext;
		it.last_run   = is_last;
		it.query_pred = PRED_W'($urandom());
		it.bag_count  = ROW_W'($urandom());
		return it;
	endfunction

	// A range query beat, with noise in the run fields.
	function automatic item_t query_beat(input logic [PRED_W-1:0] pred,
			input logic [ROW_W-1:0] bag);
		item_t it;
		it.func       = FUNC_QUERY;
		it.run_rank   = ROW_W'($urandom());
		it.run_extent = ROW_W'($urandom());
		it.last_run   = 1'($urandom_range(0, 1));
		it.query_pred = pred;
		it.bag_count  = bag;
		return it;
	endfunction

	// Only predictors that already hold a table entry are ever asked about.
	function automatic logic [PRED_W-1:0] pick_pred();
		if (preds_done >= 1024)
			return PRED_W'($urandom_range(0, 1023));
		if ($urandom_range(0, 3) == 0)
			return PRED_W'(preds_done - 1);
		return PRED_W'($urandom_range(0, preds_done - 1));
	endfunction

	// Mostly short runs so that thresholds in the tens and hundreds split dense from
	// sparse, with the odd full-width run to push merged totals into saturation.
	function automatic logic [ROW_W-1:0] pick_extent();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return ROW_W'($urandom_range(1, 32));
			6, 7, 8:          return ROW_W'($urandom_range(1, 2000));
			default:          return ROW_W'($urandom_range(1, 24'hFFFFFF));
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] pick_bag();
		case ($urandom_range(0, 7))
			0:          return '0;
			1:          return '1;
			2, 3, 4:    return ROW_W'($urandom_range(1, 500));
			default:    return ROW_W'($urandom());
		endcase
	endfunction

	// Offers one beat on the item channel and holds it until accepted. The sender
	// works in bursts; between bursts it drops valid for a random gap, and a gap of
	// zero simply joins two bursts with valid left high.
	task automatic push_beat(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			repeat (gap) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		item_ch.data  <= it;
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (it.func == FUNC_QUERY)
			queries_sent++;
		else if (it.last_run)
			preds_done++;
	endtask

	// Drops valid and waits until every predicted result has come back. A run beat
	// that is not last produces nothing, so it waits on after that to let the pipeline
	// empty before anything that needs the block idle.
	task automatic pause_until_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [ROW_W-1:0] val);
		@(negedge clk);
		cfg_ch.data  <= {idx, val};
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Register writes only ever happen with the block drained.
	task automatic apply_setting(input logic [ROW_W-1:0] rows, input int preds,
			input logic [ROW_W-1:0] thr);
		pause_until_drained();
		write_reg(REG_N_ROW, rows);
		write_reg(REG_N_PRED, ROW_W'(preds));
		write_reg(REG_DENSE_THR, thr);
		settings_used++;
	endtask

	// One random predictor: half are a single run, the rest a few or several runs.
	// Ranks come mostly from a small pool so neighbors often merge, and range
	// queries are sprinkled between the run beats.
	task automatic push_predictor();
		logic [ROW_W-1:0] pool [3];
		logic [ROW_W-1:0] rank;
		int               nruns;
		int               sel;
		sel   = $urandom_range(0, 19);
		nruns = (sel < 10) ? 1 : (sel < 17) ? $urandom_range(2, 3) : $urandom_range(4, 8);
		foreach (pool[k])
			pool[k] = ROW_W'($urandom());
		for (int k = 0; k < nruns; k++) begin
			if (preds_done > 0 && $urandom_range(0, 4) == 0)
				push_beat(query_beat(pick_pred(), pick_bag()));
			rank = ($urandom_range(0, 3) == 0) ? ROW_W'($urandom()) : pool[$urandom_range(0, 2)];
			push_beat(run_beat(rank, pick_extent(), k == nruns - 1));
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		idle_cycles     = 0;
		items_sent      = 0;
		queries_sent    = 0;
		preds_done      = 0;
		settings_used   = 0;
		burst_left      = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Reset settings first: one row per predictor, threshold zero,
		// so a single run of one row is dense and leaves nothing explicit.
		push_beat(run_beat(24'd0, 24'd1, 1'b1));
		push_beat(query_beat(10'd0, 24'd0));

		apply_setting(24'd100, 1024, 24'd5);
		// Rank 7 merges to 7 rows; rank 9 ties it with 7 plus a zero extent, and the
		// tie must keep rank 7 as the longest run.
		push_beat(run_beat(24'd7, 24'd3, 1'b0));
		push_beat(run_beat(24'd7, 24'd4, 1'b0));
		push_beat(run_beat(24'd9, 24'd7, 1'b0));
		push_beat(run_beat(24'd9, 24'd0, 1'b1));
		// Two full-width runs of the top rank: the merged total saturates and the
		// explicit count bottoms out at zero because the run exceeds the row count.
		push_beat(run_beat(24'hFFFFFF, 24'hFFFFFF, 1'b0));
		push_beat(run_beat(24'hFFFFFF, 24'hFFFFFF, 1'b1));
		// Below the threshold: a sparse predictor taking a plain slot number.
		push_beat(run_beat(24'd3, 24'd2, 1'b1));
		// Range answers for sparse and dense entries, with full-width and small bags.
		push_beat(query_beat(10'd3, 24'hFFFFFF));
		push_beat(query_beat(10'd2, 24'hFFFFFF));
		push_beat(query_beat(10'd1, 24'd1));
		push_beat(query_beat(10'd0, 24'd12345));
		// A query in the middle of a predictor must not disturb its run tracking.
		push_beat(run_beat(24'd5, 24'd6, 1'b0));
		push_beat(query_beat(10'd2, 24'd0));
		push_beat(run_beat(24'd6, 24'd6, 1'b1));

		// Random part, in phases that each run under a different register setting.
		// Enough predictors are recorded that queries reach the upper table indexes.
		phase = 0;
		while (items_sent < 1700 || preds_done < 600) begin
			case (phase % 7)
				0: apply_setting(24'hFFFFFF, 1024, 24'hFFFFFF);
				1: apply_setting(24'd1, 1, 24'd0);
				2: apply_setting(24'd64, 700, 24'd16);
				3: apply_setting(24'd5000, $urandom_range(1, 1024), 24'd200);
				4: apply_setting(ROW_W'($urandom_range(1, 24'hFFFFFF)), $urandom_range(1, 1024),
					ROW_W'($urandom()));
				5: apply_setting(24'd300, 1024, 24'd0);
				default: apply_setting(ROW_W'($urandom_range(1, 1000)), $urandom_range(1, 1024),
					ROW_W'($urandom_range(1, 40)));
			endcase
			phase_end = items_sent + 250;
			while (items_sent < phase_end) begin
				push_predictor();
				// Now and then the sender holds off until the result side is empty.
				if ($urandom_range(0, 49) == 0)
					pause_until_drained();
			end
			phase++;
		end

		// Everything is sent; wait for the last results, then a short tail so a stray
		// extra beat would still be caught.
		pause_until_drained();
		repeat (20) @(negedge clk);

		$display("Run covered %0d beats (%0d range queries) for %0d predictors under %0d settings.",
			items_sent, queries_sent, preds_done, settings_used + 1);
		$display("Checked %0d layout summaries (%0d dense) and %0d range answers, %0d mismatches.",
			layouts_seen, dense_seen, ranges_seen, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS dense_rank_layout_engine");
		end else begin
			$display("FAIL dense_rank_layout_engine");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/drle_pkg.sv
hdl/drle_stream_if.sv
hdl/drle_ram.sv
hdl/dense_rank_layout_engine.sv
hdl/drle_checker.sv
sim/drle_layout_checker.sv
sim/tb_dense_rank_layout_engine.sv
